// ===== rtl/bmhq_pkg.sv =====
`timescale 1ns / 1ps
package bmhq_pkg;
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned CNT_W = 11;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;
endpackage

// ===== rtl/bmhq_ram.sv =====
`timescale 1ns / 1ps
module bmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/binary_min_heap_queue.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Ports                                   Handshake
// input     in         start, in_opcode, in_key_value          start & !busy
// result    out        out_strobe, out_status,                 strobe, one cycle
//                      out_result_value, out_entry_count
// Insert writes the key at the end of the heap and moves it up while it is less than its parent.
// Extract reads the root, moves the last key to the root and sifts it down.
// Remove scans the entries in order for the key, then moves the last key and sifts it down and up.
// All cost comes from the single read port of the heap memory.
// Reset clears the count and control only; the memory needs no clearing.
// The receiver cannot stall: the result strobe comes in the first idle cycle.
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_opcode,
  input  logic signed [31:0]          in_key_value,
  output logic                        out_strobe,
  output logic [1:0]                  out_status,
  output logic signed [31:0]          out_result_value,
  output logic [10:0]                 out_entry_count
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PW = $clog2(CAPACITY + 1) + 1;

  typedef enum logic [14:0] {
    S_IDLE   = 15'd1,
    S_SCAN   = 15'd2,
    S_SCANW  = 15'd4,
    S_MOVE   = 15'd8,
    S_MOVEW  = 15'd16,
    S_MOVEP  = 15'd32,
    S_DNA    = 15'd64,
    S_DNL    = 15'd128,
    S_DNR    = 15'd256,
    S_DNC    = 15'd512,
    S_UPA    = 15'd1024,
    S_UPW    = 15'd2048,
    S_UPC    = 15'd4096,
    S_DONE   = 15'd8192,
    S_XRD    = 15'd16384
  } state_t;

  state_t             state_r, state_nxt;
  logic [PW-1:0]      cnt_r, cnt_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [PW-1:0]      pick_r, pick_nxt;
  logic [31:0]        cur_r, cur_nxt;
  logic [31:0]        lv_r, lv_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [31:0]        val_r, val_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [1:0]         st_r, st_nxt;
  logic               strobe_r, strobe_nxt;
  logic               upafter_r, upafter_nxt;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;

  bmhq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic lt(input logic [31:0] a, input logic [31:0] b);
    lt = $signed(a) < $signed(b);
  endfunction

  logic [PW-1:0] lc, rc, par;
  assign lc  = PW'({pos_r, 1'b1});
  assign rc  = lc + PW'(1);
  assign par = (pos_r - PW'(1)) >> 1;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; pos_nxt = pos_r; pick_nxt = pick_r;
    cur_nxt = cur_r; lv_nxt = lv_r; key_nxt = key_r; val_nxt = val_r;
    op_nxt = op_r; st_nxt = st_r; strobe_nxt = 1'b0; upafter_nxt = upafter_r;
    we = 1'b0; waddr = AW'(pos_r); wdata = cur_r; raddr = AW'(pos_r);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_opcode; key_nxt = in_key_value; st_nxt = bmhq_pkg::ST_OK;
          val_nxt = '0; upafter_nxt = 1'b0;
          unique case (bmhq_pkg::opcode_t'(in_opcode))
            bmhq_pkg::OP_INSERT: begin
              if (cnt_r >= PW'(CAPACITY)) begin
                st_nxt = bmhq_pkg::ST_FULL; state_nxt = S_DONE;
              end else begin
                val_nxt = in_key_value; cur_nxt = in_key_value;
                pos_nxt = cnt_r; cnt_nxt = cnt_r + PW'(1); state_nxt = S_UPA;
              end
            end
            bmhq_pkg::OP_EXTRACT: begin
              if (cnt_r == '0) begin
                st_nxt = bmhq_pkg::ST_EMPTY; state_nxt = S_DONE;
              end else begin
                pos_nxt = '0; raddr = '0; state_nxt = S_XRD;
              end
            end
            bmhq_pkg::OP_REMOVE: begin
              pos_nxt = '0; raddr = '0;
              if (cnt_r == '0) begin
                st_nxt = bmhq_pkg::ST_MISSING; state_nxt = S_DONE;
              end else begin
                state_nxt = S_SCANW;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_XRD: begin
        val_nxt = rdata; raddr = AW'(cnt_r - PW'(1)); state_nxt = S_MOVEW;
      end
      S_SCANW: state_nxt = S_SCAN;
      S_SCAN: begin
        if (rdata == key_r) begin
          val_nxt = rdata; raddr = AW'(cnt_r - PW'(1)); state_nxt = S_MOVEW;
        end else if (pos_r + PW'(1) >= cnt_r) begin
          st_nxt = bmhq_pkg::ST_MISSING; state_nxt = S_DONE;
        end else begin
          pos_nxt = pos_r + PW'(1); raddr = AW'(pos_r + PW'(1)); state_nxt = S_SCANW;
        end
      end
      S_MOVEW: begin
        raddr = AW'(cnt_r - PW'(1)); state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cnt_nxt = cnt_r - PW'(1);
        cur_nxt = rdata;
        upafter_nxt = (op_r == bmhq_pkg::OP_REMOVE);
        if (pos_r >= cnt_r - PW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          we = 1'b1; wdata = rdata; state_nxt = S_DNA;
        end
      end
      S_DNA: begin
        if (lc >= cnt_r) begin
          state_nxt = upafter_r ? S_UPA : S_DONE;
        end else begin
          raddr = AW'(lc); state_nxt = S_DNL;
        end
      end
      S_DNL: begin
        lv_nxt = rdata; pick_nxt = lc;
        if (rc < cnt_r) begin
          raddr = AW'(rc); state_nxt = S_DNR;
        end else begin
          state_nxt = S_DNC;
        end
      end
      S_DNR: begin
        if (lt(rdata, lv_r)) begin
          lv_nxt = rdata; pick_nxt = rc;
        end
        state_nxt = S_DNC;
      end
      S_DNC: begin
        if (lt(cur_r, lv_r)) begin
          state_nxt = upafter_r ? S_UPA : S_DONE;
        end else begin
          we = 1'b1; waddr = AW'(pos_r); wdata = lv_r;
          pos_nxt = pick_r; state_nxt = S_MOVEP;
        end
      end
      S_MOVEP: begin
        we = 1'b1; waddr = AW'(pos_r); wdata = cur_r; state_nxt = S_DNA;
      end
      S_UPA: begin
        we = 1'b1; waddr = AW'(pos_r); wdata = cur_r;
        if (pos_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          raddr = AW'(par); state_nxt = S_UPW;
        end
      end
      S_UPW: begin
        raddr = AW'(par); state_nxt = S_UPC;
      end
      S_UPC: begin
        if (lt(cur_r, rdata)) begin
          we = 1'b1; waddr = AW'(pos_r); wdata = rdata;
          pos_nxt = par; state_nxt = S_UPA;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        strobe_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; strobe_r <= strobe_nxt;
    end
    pos_r <= pos_nxt; pick_r <= pick_nxt; cur_r <= cur_nxt; lv_r <= lv_nxt;
    key_r <= key_nxt; val_r <= val_nxt; op_r <= op_nxt; st_r <= st_nxt;
    upafter_r <= upafter_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = strobe_r;
  assign out_status       = st_r;
  assign out_result_value = val_r;
  assign out_entry_count  = 11'(cnt_r);
endmodule

// ===== rtl/bmhq_checker.sv =====
`timescale 1ns / 1ps
module bmhq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [31:0] out_result_value,
  input logic [10:0] out_entry_count
);
  a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("double strobe");
  a_idle_after_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("busy at strobe");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("no busy after accept");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != bmhq_pkg::ST_OK) |-> out_result_value == '0)
    else $error("error with value");
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == bmhq_pkg::ST_EMPTY) |-> out_entry_count == '0)
    else $error("empty with count");
endmodule

bind binary_min_heap_queue bmhq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_strobe(out_strobe),
  .out_status(out_status), .out_result_value(out_result_value),
  .out_entry_count(out_entry_count)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  localparam int unsigned CAP = 1024;
  localparam longint CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = bmhq_pkg::OP_NOP;
  logic signed [31:0] in_key_value = '0;
  logic out_strobe;
  logic [1:0] out_status;
  logic signed [31:0] out_result_value;
  logic [10:0] out_entry_count;

  typedef struct packed {
    bmhq_pkg::status_t status;
    logic signed [31:0] value;
    logic [10:0] count;
  } heap_result_t;

  logic signed [31:0] heap_model[CAP];
  int unsigned model_count = 0;
  heap_result_t pending_results[$];
  int errors = 0;
  longint cycles = 0;

  binary_min_heap_queue #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_key_value(in_key_value),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_result_value(out_result_value), .out_entry_count(out_entry_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void swap_keys(int unsigned i, int unsigned j);
    logic signed [31:0] t;
    t = heap_model[i];
    heap_model[i] = heap_model[j];
    heap_model[j] = t;
  endfunction

  function automatic void bubble_up(int unsigned pos);
    int unsigned parent;
    while (pos > 0 && pos < model_count) begin
      parent = (pos - 1) / 2;
      if (!(heap_model[pos] < heap_model[parent])) break;
      swap_keys(pos, parent);
      pos = parent;
    end
  endfunction

  function automatic void bubble_down(int unsigned pos);
    int unsigned lc, rc, pick;
    while (pos < model_count) begin
      lc = 2 * pos + 1;
      rc = 2 * pos + 2;
      pick = lc;
      if (lc >= model_count) break;
      if (rc < model_count && heap_model[rc] < heap_model[lc]) pick = rc;
      if (heap_model[pos] < heap_model[pick]) break;
      swap_keys(pos, pick);
      pos = pick;
    end
  endfunction

  function automatic heap_result_t apply_heap_op(bmhq_pkg::opcode_t op,
                                                 logic signed [31:0] key);
    heap_result_t r;
    int unsigned pos;
    r.status = bmhq_pkg::ST_OK;
    r.value = '0;
    case (op)
      bmhq_pkg::OP_INSERT: begin
        if (model_count >= CAP) begin
          r.status = bmhq_pkg::ST_FULL;
        end else begin
          heap_model[model_count] = key;
          model_count++;
          bubble_up(model_count - 1);
          r.value = key;
        end
      end
      bmhq_pkg::OP_EXTRACT: begin
        if (model_count == 0) begin
          r.status = bmhq_pkg::ST_EMPTY;
        end else begin
          r.value = heap_model[0];
          heap_model[0] = heap_model[model_count - 1];
          model_count--;
          bubble_down(0);
        end
      end
      bmhq_pkg::OP_REMOVE: begin
        pos = 0;
        while (pos < model_count && heap_model[pos] != key) pos++;
        if (pos >= model_count) begin
          r.status = bmhq_pkg::ST_MISSING;
        end else begin
          r.value = heap_model[pos];
          heap_model[pos] = heap_model[model_count - 1];
          model_count--;
          if (pos < model_count) begin
            bubble_down(pos);
            bubble_up(pos);
          end
        end
      end
      default: ;
    endcase
    r.count = model_count[10:0];
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t exp_r;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d value %0d count %0d",
               out_status, out_result_value, out_entry_count);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_status);
          errors++;
        end
        if (out_result_value !== exp_r.value) begin
          $error("result_value: expected %0d, actual %0d", exp_r.value,
                 out_result_value);
          errors++;
        end
        if (out_entry_count !== exp_r.count) begin
          $error("entry_count: expected %0d, actual %0d", exp_r.count,
                 out_entry_count);
          errors++;
        end
      end
    end
  end

  int burst_left = 0;

  // Sends one beat, with random gaps between bursts when idling is enabled.
  task automatic send_op(bmhq_pkg::opcode_t op, logic signed [31:0] key,
                         bit idle = 1'b1);
    int gap;
    if (idle) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    start <= 1'b1;
    in_opcode <= op;
    in_key_value <= key;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_heap_op(op, key));
  endtask

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15) - 8;
      1: return 32'sh7fffffff - $urandom_range(0, 3);
      2: return 32'sh80000000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] held_or_random();
    if (model_count > 0 && $urandom_range(0, 3) != 0)
      return heap_model[$urandom_range(0, model_count - 1)];
    return rand_key();
  endfunction

  task automatic test_directed();
    send_op(bmhq_pkg::OP_EXTRACT, 0, 1'b0);
    send_op(bmhq_pkg::OP_REMOVE, 5, 1'b0);
    send_op(bmhq_pkg::OP_NOP, 32'sh7fffffff, 1'b0);
    send_op(bmhq_pkg::OP_INSERT, 32'sh7fffffff, 1'b0);
    send_op(bmhq_pkg::OP_INSERT, 32'sh80000000, 1'b0);
    send_op(bmhq_pkg::OP_INSERT, 0, 1'b0);
    send_op(bmhq_pkg::OP_INSERT, -1, 1'b0);
    send_op(bmhq_pkg::OP_INSERT, 0, 1'b0);
    send_op(bmhq_pkg::OP_INSERT, 32'sh55555555, 1'b0);
    send_op(bmhq_pkg::OP_INSERT, 32'shaaaaaaaa, 1'b0);
    send_op(bmhq_pkg::OP_REMOVE, 12345, 1'b0);
    send_op(bmhq_pkg::OP_REMOVE, 0, 1'b0);
    send_op(bmhq_pkg::OP_REMOVE, 32'sh55555555, 1'b0);
    send_op(bmhq_pkg::OP_NOP, 0, 1'b0);
    send_op(bmhq_pkg::OP_EXTRACT, 0, 1'b0);
    send_op(bmhq_pkg::OP_EXTRACT, 0, 1'b0);
    send_op(bmhq_pkg::OP_REMOVE, 32'sh7fffffff, 1'b0);
    send_op(bmhq_pkg::OP_EXTRACT, 0, 1'b0);
    send_op(bmhq_pkg::OP_EXTRACT, 0, 1'b0);
    send_op(bmhq_pkg::OP_EXTRACT, 0, 1'b0);
    send_op(bmhq_pkg::OP_EXTRACT, 0, 1'b0);
  endtask

  task automatic test_random_mix(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) send_op(bmhq_pkg::OP_INSERT, rand_key());
      else if (sel < 70) send_op(bmhq_pkg::OP_EXTRACT, $urandom);
      else if (sel < 97) send_op(bmhq_pkg::OP_REMOVE, held_or_random());
      else send_op(bmhq_pkg::OP_NOP, $urandom);
    end
  endtask

  // The heap is filled to capacity, then overfilled and partly drained.
  task automatic test_fill_to_capacity();
    while (model_count < CAP) send_op(bmhq_pkg::OP_INSERT, rand_key(), 1'b0);
    send_op(bmhq_pkg::OP_INSERT, 1, 1'b0);
    send_op(bmhq_pkg::OP_INSERT, 32'sh80000000, 1'b0);
    send_op(bmhq_pkg::OP_REMOVE, heap_model[CAP - 1], 1'b0);
    send_op(bmhq_pkg::OP_INSERT, 32'sh7fffffff, 1'b0);
    send_op(bmhq_pkg::OP_INSERT, 2, 1'b0);
    repeat (40) send_op(bmhq_pkg::OP_EXTRACT, 0);
    repeat (40) send_op(bmhq_pkg::OP_REMOVE, held_or_random());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(150);
    test_fill_to_capacity();
    test_random_mix(100);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
